// ===== src/sharp_pkg.sv =====
// ----------------------------------------------------------------------------
// sharp_pkg
// shared codes, reset values and stage record of the cross sharpen unit
// ----------------------------------------------------------------------------
package sharp_pkg;

  // operation codes of an input word
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic CFG_ROW_BYTES = 1'b0;
  localparam logic CFG_CHANNELS  = 1'b1;

  localparam logic [12:0] ROW_BYTES_RESET = 13'd640;
  localparam logic [1:0]  CHANNELS_RESET  = 2'd1;

  // per-word control carried from the read stage to the write-back stage
  typedef struct packed {
    logic       result;        // word produces an output
    logic       last;          // last column of the row
    logic       frame_end;     // last word of the drained row
    logic       write_center;  // incoming byte goes to the center store
    logic       drain;         // bottom neighbor replicates the center
    logic       top;           // top neighbor replicates the center
    logic       has_left;
    logic       has_right;
    logic [7:0] pix;
  } stage_t;

endpackage

// ===== src/sharpen_cross_filter_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// sharpen_cross_filter_3x3_unit
// streaming 5*center minus cross sharpen over channel-interleaved raster bytes
// ----------------------------------------------------------------------------
// pipeline: the stores are read into the read stage on the accepting edge, and the
//   add/clamp result is loaded into the output register when that stage advances
// throughput: one word per cycle unless the output stalls; each store has
//   two read ports and one write port; a word's write-back is forwarded to the next
// reset: synchronous, clears row tracking and the pipeline; the line stores
//   are not cleared and hold undefined bytes until a row is written
module sharpen_cross_filter_3x3_unit #(
  parameter int MAX_ROW_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  pixel_value,
  input  logic        start_of_frame,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  sharpened_value,
  output logic        end_of_row,
  output logic        end_of_frame
);

  localparam int AW = $clog2(MAX_ROW_BYTES);   // store address width
  localparam int RW = AW + 1;                   // holds the row length itself
  localparam int EW = (RW > 13) ? RW : 13;      // compare width for clamping

  // configuration registers
  logic [12:0] row_bytes;
  logic [1:0]  channels;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= sharp_pkg::ROW_BYTES_RESET;
      channels  <= sharp_pkg::CHANNELS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sharp_pkg::CFG_ROW_BYTES: row_bytes <= cfg_data;
        sharp_pkg::CFG_CHANNELS:  channels  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // effective row length and stride: zero counts as one, length saturates
  logic [EW-1:0] rb_ext;
  logic [RW-1:0] rb_eff;
  logic [1:0]    ch_eff;

  always_comb begin
    rb_ext = EW'(row_bytes);
    if (rb_ext == '0) begin
      rb_ext = EW'(1);
    end else if (rb_ext > EW'(MAX_ROW_BYTES)) begin
      rb_ext = EW'(MAX_ROW_BYTES);
    end
    rb_eff = RW'(rb_ext);
    ch_eff = (channels == 2'd0) ? 2'd1 : channels;
  end

  // row tracking
  logic [AW-1:0] column_position;
  logic          center_row_valid;
  logic          center_is_top_row;

  // read stage register
  logic                s1_valid;
  sharp_pkg::stage_t   s1;
  logic [AW-1:0]       s1_col;
  logic [AW-1:0]       s1_col_l;
  logic [AW-1:0]       s1_col_r;

  logic acc;      // input word accepted
  logic s1_adv;   // read stage word completes and writes back

  assign s1_adv   = s1_valid && (!s1.result || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign acc      = in_valid && !in_stall;

  // front end: start of frame clears tracking before the word is used
  logic          v0;
  logic          top0;
  logic [AW-1:0] cp0;
  logic [AW-1:0] col;
  logic          last0;
  logic          has_left0;
  logic          has_right0;
  logic [AW-1:0] addr_l;
  logic [AW-1:0] addr_r;
  sharp_pkg::stage_t s0;

  always_comb begin
    v0   = start_of_frame ? 1'b0 : center_row_valid;
    top0 = start_of_frame ? 1'b1 : center_is_top_row;
    cp0  = start_of_frame ? '0 : column_position;
    // column restarts when the row got shorter
    col  = ({1'b0, cp0} >= rb_eff) ? '0 : cp0;
    last0      = (({1'b0, col} + RW'(1)) == rb_eff);
    has_left0  = (col >= AW'(ch_eff));
    has_right0 = (({1'b0, col} + RW'(ch_eff)) < rb_eff);
    addr_l     = col - AW'(ch_eff);
    addr_r     = col + AW'(ch_eff);

    s0.result       = v0;
    s0.last         = last0;
    s0.frame_end    = v0 && (operation == sharp_pkg::OP_DRAIN) && last0;
    s0.write_center = (operation == sharp_pkg::OP_PIXEL);
    s0.drain        = (operation == sharp_pkg::OP_DRAIN);
    s0.top          = top0;
    s0.has_left     = has_left0;
    s0.has_right    = has_right0;
    s0.pix          = pixel_value;
  end

  // tracking update at accept
  logic [AW-1:0] column_position_next;
  logic          center_row_valid_next;
  logic          center_is_top_row_next;

  always_comb begin
    column_position_next   = col;
    center_row_valid_next  = v0;
    center_is_top_row_next = top0;
    if (!v0) begin
      // first row of a frame is only stored; drain with no row does nothing
      if (operation == sharp_pkg::OP_PIXEL) begin
        if (last0) begin
          column_position_next  = '0;
          center_row_valid_next = 1'b1;
        end else begin
          column_position_next = col + AW'(1);
        end
      end
    end else if (operation == sharp_pkg::OP_PIXEL) begin
      if (last0) begin
        column_position_next   = '0;
        center_is_top_row_next = 1'b0;
      end else begin
        column_position_next = col + AW'(1);
      end
    end else begin
      // drain of the held row
      if (last0) begin
        column_position_next   = '0;
        center_row_valid_next  = 1'b0;
        center_is_top_row_next = 1'b1;
      end else begin
        column_position_next = col + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position   <= '0;
      center_row_valid  <= 1'b0;
      center_is_top_row <= 1'b1;
    end else if (acc) begin
      column_position   <= column_position_next;
      center_row_valid  <= center_row_valid_next;
      center_is_top_row <= center_is_top_row_next;
    end
  end

  // read stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1       <= s0;
      s1_col   <= col;
      s1_col_l <= addr_l;
      s1_col_r <= addr_r;
    end
  end

  // line stores: two read ports, one write port each
  logic [7:0] center_mem [MAX_ROW_BYTES];
  logic [7:0] above_mem  [MAX_ROW_BYTES];
  logic [7:0] center_rd_c;
  logic [7:0] center_rd_r;
  logic [7:0] above_rd_c;
  logic [7:0] above_rd_l;

  logic       center_we;
  logic       above_we;
  logic [7:0] c_val;

  assign center_we = s1_adv && s1.write_center;
  assign above_we  = s1_adv && s1.result;

  always_ff @(posedge clk) begin
    if (center_we) begin
      center_mem[s1_col] <= s1.pix;
    end
    if (acc) begin
      center_rd_c <= center_mem[col];
      center_rd_r <= center_mem[addr_r];
    end
  end

  // old center byte moves into the above store as the column is consumed
  always_ff @(posedge clk) begin
    if (above_we) begin
      above_mem[s1_col] <= c_val;
    end
    if (acc) begin
      above_rd_c <= above_mem[col];
      above_rd_l <= above_mem[addr_l];
    end
  end

  // forwarding of the write-back that coincided with this word's read
  logic          fwd_c_en;
  logic [AW-1:0] fwd_c_addr;
  logic [7:0]    fwd_c_data;
  logic          fwd_a_en;
  logic [AW-1:0] fwd_a_addr;
  logic [7:0]    fwd_a_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_c_en <= 1'b0;
      fwd_a_en <= 1'b0;
    end else if (acc) begin
      fwd_c_en <= center_we;
      fwd_a_en <= above_we;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      fwd_c_addr <= s1_col;
      fwd_c_data <= s1.pix;
      fwd_a_addr <= s1_col;
      fwd_a_data <= c_val;
    end
  end

  // kernel: 5*c - up - down - left - right, clamped
  logic [7:0]         right_val;
  logic [7:0]         up_val;
  logic [7:0]         left_val;
  logic [7:0]         up_n;
  logic [7:0]         down_n;
  logic [7:0]         left_n;
  logic [7:0]         right_n;
  logic [10:0]        c5;
  logic signed [11:0] sum;
  logic [7:0]         clamped;

  always_comb begin
    c_val     = (fwd_c_en && fwd_c_addr == s1_col)   ? fwd_c_data : center_rd_c;
    right_val = (fwd_c_en && fwd_c_addr == s1_col_r) ? fwd_c_data : center_rd_r;
    up_val    = (fwd_a_en && fwd_a_addr == s1_col)   ? fwd_a_data : above_rd_c;
    left_val  = (fwd_a_en && fwd_a_addr == s1_col_l) ? fwd_a_data : above_rd_l;

    // missing neighbors replicate the center
    up_n    = s1.top       ? c_val : up_val;
    down_n  = s1.drain     ? c_val : s1.pix;
    left_n  = s1.has_left  ? left_val : c_val;
    right_n = s1.has_right ? right_val : c_val;

    c5  = {1'b0, c_val, 2'b00} + {3'b000, c_val};
    sum = $signed({1'b0, c5}) - $signed({4'b0000, up_n}) - $signed({4'b0000, down_n})
        - $signed({4'b0000, left_n}) - $signed({4'b0000, right_n});

    if (sum < 12'sd0) begin
      clamped = 8'd0;
    end else if (sum > 12'sd255) begin
      clamped = 8'd255;
    end else begin
      clamped = sum[7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1.result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.result) begin
      sharpened_value <= clamped;
      end_of_row      <= s1.last;
      end_of_frame    <= s1.frame_end;
    end
  end

  // a frame end word always closes a row
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!end_of_frame || end_of_row))
    else $error("end_of_frame without end_of_row");

  // draining the last column releases the held row
  assert property (@(posedge clk) disable iff (rst)
    (acc && v0 && operation == sharp_pkg::OP_DRAIN && last0) |=> !center_row_valid)
    else $error("row still held after final drain word");

  // a stalled output word holds still
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sharpened_value)
      && $stable(end_of_row) && $stable(end_of_frame)))
    else $error("stalled output word changed");

endmodule

// ===== sim/tb_sharpen_cross_filter_3x3_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sharpen_cross_filter_3x3_unit
// self-checking bench for the streaming 3x3 cross sharpen unit: it replays
// directed frames and random frame traffic, predicts every output word from
// its own copy of the line stores, and compares the words in arrival order
// ----------------------------------------------------------------------------
module tb_sharpen_cross_filter_3x3_unit;

  localparam int MAX_ROW       = 4096;
  localparam int CENTER_GAIN   = 5;
  localparam int PIXEL_MAX     = 255;
  // the output register trails acceptance by the read stage; give words that make
  // no result some room before the configuration changes
  localparam int SETTLE_CYCLES = 8;
  // long receiver hold-off used to back the unit up into its input
  localparam int HOLD_CYCLES   = 200;
  // slowest run: well under 3000 words at the heaviest idling and stalling, plus the
  // settle gaps and the hold-off, all taken many times over
  localparam int CYCLE_LIMIT   = 200000;

  // one expected output word
  typedef struct packed {
    logic [7:0] sharpened;
    logic       row_end;
    logic       frame_end;
  } sharp_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = sharp_pkg::CFG_ROW_BYTES;
  logic [12:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = sharp_pkg::OP_PIXEL;
  logic [7:0]  pixel_value = '0;
  logic        start_of_frame = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  sharpened_value;
  logic        end_of_row;
  logic        end_of_frame;

  sharpen_cross_filter_3x3_unit #(.MAX_ROW_BYTES(MAX_ROW)) dut (.*);

  // ---------------------------------------------------------------------------
  // predictor state: line stores, row tracking and register copies
  // ---------------------------------------------------------------------------
  logic [7:0]  above_row [MAX_ROW];
  logic [7:0]  center_row [MAX_ROW];
  int unsigned col_pos = 0;
  bit          row_held = 1'b0;
  bit          top_row = 1'b1;
  logic [12:0] row_bytes_reg = sharp_pkg::ROW_BYTES_RESET;
  logic [1:0]  channels_reg = sharp_pkg::CHANNELS_RESET;

  sharp_word_t expected_words[$];
  sharp_word_t want;
  int          failures = 0;
  int          words_used = 0;   // words that store or emit something
  int unsigned cycle_count = 0;

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int holds_granted = 0;
  int hold_left = 0;

  // ---------------------------------------------------------------------------
  // clock, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  // zero means 1, anything past the store depth saturates
  function automatic int unsigned eff_row_bytes();
    int unsigned rb;
    rb = row_bytes_reg;
    if (rb == 0) rb = 1;
    if (rb > MAX_ROW) rb = MAX_ROW;
    return rb;
  endfunction

  function automatic int unsigned eff_channels();
    return (channels_reg == 2'd0) ? 1 : int'(channels_reg);
  endfunction

  // cross kernel at one center column; the left neighbor was already
  // replaced by the new row, so it comes from the above store, where each
  // consumed center byte is parked
  function automatic logic [7:0] sharpen_column(int unsigned col, int unsigned rb,
                                                int unsigned ch, logic [7:0] below);
    int c, up, left, right, sum;
    c = center_row[col];
    up = top_row ? c : int'(above_row[col]);
    left = (col >= ch) ? int'(above_row[col - ch]) : c;
    right = (col + ch < rb) ? int'(center_row[col + ch]) : c;
    sum = CENTER_GAIN * c - up - int'(below) - left - right;
    if (sum > PIXEL_MAX) sum = PIXEL_MAX;
    if (sum < 0) sum = 0;
    above_row[col] = c[7:0];
    return sum[7:0];
  endfunction

  function automatic void predict_word(logic op, logic [7:0] pix, logic sof);
    int unsigned rb, ch, col;
    bit          last;
    sharp_word_t w;
    rb = eff_row_bytes();
    ch = eff_channels();
    if (sof) begin
      col_pos = 0;
      row_held = 1'b0;
      top_row = 1'b1;
    end
    // row length lowered mid-row: restart the column
    if (col_pos >= rb) col_pos = 0;
    col = col_pos;
    last = (col + 1 == rb);
    // first row of a frame is only stored; drains with no row are dropped
    if (!row_held) begin
      if (op != sharp_pkg::OP_PIXEL) return;
      center_row[col] = pix;
      words_used++;
      if (last) begin
        col_pos = 0;
        row_held = 1'b1;
      end else begin
        col_pos = col + 1;
      end
      return;
    end
    words_used++;
    if (op == sharp_pkg::OP_PIXEL) begin
      w.sharpened = sharpen_column(col, rb, ch, pix);
      center_row[col] = pix;
      w.row_end = last;
      w.frame_end = 1'b0;
      if (last) begin
        col_pos = 0;
        top_row = 1'b0;
      end else begin
        col_pos = col + 1;
      end
    end else begin
      // drain: bottom edge replicates the center
      w.sharpened = sharpen_column(col, rb, ch, center_row[col]);
      w.row_end = last;
      w.frame_end = last;
      if (last) begin
        col_pos = 0;
        row_held = 1'b0;
        top_row = 1'b1;
      end else begin
        col_pos = col + 1;
      end
    end
    expected_words.push_back(w);
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stall, plus an occasional long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (holds_granted != holds_requested) begin
        holds_granted = holds_requested;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: oldest expectation against each accepted output word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word: sharpened_value %0d", sharpened_value);
        failures++;
      end else begin
        want = expected_words.pop_front();
        if (sharpened_value !== want.sharpened) begin
          $error("sharpened_value: expected %0d, got %0d", want.sharpened,
                 sharpened_value);
          failures++;
        end
        if (end_of_row !== want.row_end) begin
          $error("end_of_row: expected %0b, got %0b", want.row_end, end_of_row);
          failures++;
        end
        if (end_of_frame !== want.frame_end) begin
          $error("end_of_frame: expected %0b, got %0b", want.frame_end, end_of_frame);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side helpers
  // ---------------------------------------------------------------------------
  // offers one word after a random gap; returns at the accepting edge with
  // valid left high so back-to-back words never drop it
  task automatic send_word(input logic op, input logic [7:0] pix, input logic sof);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    pixel_value <= pix;
    start_of_frame <= sof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(op, pix, sof);
  endtask

  // stop offering, wait for every expected word, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes both registers on consecutive edges; only called when idle
  task automatic load_config(input logic [12:0] rb, input logic [1:0] ch);
    cfg_write <= 1'b1;
    cfg_index <= sharp_pkg::CFG_ROW_BYTES;
    cfg_data <= rb;
    @(posedge clk);
    row_bytes_reg = rb;
    cfg_index <= sharp_pkg::CFG_CHANNELS;
    cfg_data <= {11'd0, ch};
    @(posedge clk);
    channels_reg = ch;
    cfg_write <= 1'b0;
  endtask

  // extremes show up often so the clamp saturates both ways
  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // well-formed frame: full rows, then a full drain row
  task automatic send_frame(input int rows);
    int unsigned rb;
    rb = eff_row_bytes();
    for (int r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < rb; c++) begin
        send_word(sharp_pkg::OP_PIXEL, rand_pixel(), (r == 0) && (c == 0));
      end
    end
    for (int unsigned c = 0; c < rb; c++) begin
      send_word(sharp_pkg::OP_DRAIN, 8'($urandom), 1'b0);
    end
  endtask

  // broken traffic: mixed pixels and drains, stray frame starts, cut rows
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_word(($urandom_range(1) == 0) ? sharp_pkg::OP_PIXEL : sharp_pkg::OP_DRAIN,
                rand_pixel(), (i == 0) || ($urandom_range(9) == 0));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // 2-byte stride on a 3-byte row: middle column has no right neighbor
  task automatic test_cross_kernel();
    settle();
    load_config(13'd3, 2'd2);
    send_word(sharp_pkg::OP_PIXEL, 8'd255, 1'b1);
    send_word(sharp_pkg::OP_PIXEL, 8'd0, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd128, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd0, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd255, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd7, 1'b0);
    repeat (3) send_word(sharp_pkg::OP_DRAIN, 8'd0, 1'b0);
  endtask

  // zero registers act as 1; frame-start and drain corner cases
  task automatic test_corner_cases();
    settle();
    load_config(13'd0, 2'd0);
    send_word(sharp_pkg::OP_DRAIN, 8'hA5, 1'b1);   // frame start on a drain
    send_word(sharp_pkg::OP_DRAIN, 8'h5A, 1'b0);   // drain with no row held
    send_word(sharp_pkg::OP_PIXEL, 8'd200, 1'b1);
    send_word(sharp_pkg::OP_PIXEL, 8'd10, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd255, 1'b0);
    send_word(sharp_pkg::OP_DRAIN, 8'd0, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd90, 1'b1);
    send_word(sharp_pkg::OP_PIXEL, 8'd30, 1'b1);   // held row dropped by a new frame
    send_word(sharp_pkg::OP_DRAIN, 8'd0, 1'b0);    // single-row frame
    send_word(sharp_pkg::OP_PIXEL, 8'd1, 1'b1);
    send_word(sharp_pkg::OP_DRAIN, 8'd0, 1'b1);    // frame start on a drain drops the row
  endtask

  // row length lowered while the column sits past the new end
  task automatic test_row_shrink();
    settle();
    load_config(13'd4, 2'd1);
    send_word(sharp_pkg::OP_PIXEL, 8'd40, 1'b1);
    send_word(sharp_pkg::OP_PIXEL, 8'd250, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd3, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd99, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd0, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd255, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd17, 1'b0);
    settle();
    load_config(13'd2, 2'd1);
    send_word(sharp_pkg::OP_PIXEL, 8'd64, 1'b0);
    send_word(sharp_pkg::OP_PIXEL, 8'd128, 1'b0);
    repeat (2) send_word(sharp_pkg::OP_DRAIN, 8'd0, 1'b0);
  endtask

  // all-ones row length saturates to the store depth: a partial row is
  // stored, then the row is shortened so the column restarts mid-frame
  task automatic test_widest_row();
    settle();
    send_idle_pct = 0;
    stall_pct = 0;
    load_config(13'h1FFF, 2'd3);
    for (int c = 0; c < 24; c++) begin
      send_word(sharp_pkg::OP_PIXEL, rand_pixel(), c == 0);
    end
    settle();
    load_config(13'd6, 2'd3);
    repeat (12) send_word(sharp_pkg::OP_PIXEL, rand_pixel(), 1'b0);
    repeat (6) send_word(sharp_pkg::OP_DRAIN, 8'd0, 1'b0);
  endtask

  // receiver holds off while the sender keeps offering, filling the pipe
  task automatic test_backpressure();
    settle();
    send_idle_pct = 0;
    stall_pct = 0;
    load_config(13'd16, 2'd3);
    holds_requested++;
    send_frame(2);
  endtask

  // random configurations, each followed by a few frames
  task automatic test_random_frames(input int count, input int idle_pct,
                                    input int stall_in_pct);
    int target, pick, rb, frames;
    settle();
    send_idle_pct = idle_pct;
    stall_pct = stall_in_pct;
    target = words_used + count;
    while (words_used < target) begin
      pick = $urandom_range(99);
      if (pick < 8) rb = 0;
      else if (pick < 16) rb = 1;
      else if (pick < 75) rb = $urandom_range(12, 2);
      else rb = $urandom_range(40, 13);
      settle();
      load_config(13'(rb), 2'($urandom_range(3)));
      // first word after every write starts a frame, so a longer row never
      // reads bytes that were not written
      frames = $urandom_range(3, 1);
      repeat (frames) begin
        if ($urandom_range(9) < 8) send_frame($urandom_range(4, 1));
        else send_noise($urandom_range(2 * eff_row_bytes() + 2, 1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cross_kernel();
    test_corner_cases();
    test_row_shrink();
    test_widest_row();
    test_backpressure();
    test_random_frames(50, 0, 0);
    test_random_frames(50, 71, 0);
    test_random_frames(50, 0, 71);
    test_random_frames(50, 21, 21);
    settle();

    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sharp_pkg.sv
src/sharpen_cross_filter_3x3_unit.sv
sim/tb_sharpen_cross_filter_3x3_unit.sv
